>>> src/rmte_pkg.sv
// Shared types, constants and the arctangent table for the Euler angle extractor.
package rmte_pkg;

   localparam int MaxSteps   = 24;
   localparam int VecWidth   = 36;   // holds 2^15 * 2^14 grown by CORDIC gain
   localparam int AngWidth   = 34;   // radians * 2^29, up to about 2*pi
   localparam int SqrtSteps  = 15;   // result bits of the 30-bit radicand root

   localparam logic signed [AngWidth-1:0] PiZ = 34'sd1686629713;
   localparam logic signed [15:0] HalfPiOut = 16'sd12868;
   localparam logic signed [16:0] OneQ14 = 17'sd16384;

   typedef logic signed [VecWidth-1:0] vec_type;
   typedef logic signed [AngWidth-1:0] ang_type;

   // One CORDIC lane: vector, accumulated angle, and a forced-result override.
   typedef struct packed {
      vec_type          x;
      vec_type          y;
      ang_type          z;
      logic             force_en;
      logic signed [15:0] force_val;
   } lane_type;

   // State handed between square root cells.
   typedef struct packed {
      logic [29:0] rem;
      logic [15:0] root;
   } sqrt_type;

   function automatic ang_type atan_entry(input logic [4:0] i);
      case (i)
         5'd0: return 34'sd421657428;
         5'd1: return 34'sd248918915;
         5'd2: return 34'sd131521918;
         5'd3: return 34'sd66762579;
         5'd4: return 34'sd33510843;
         5'd5: return 34'sd16771758;
         5'd6: return 34'sd8387925;
         5'd7: return 34'sd4194219;
         5'd8: return 34'sd2097141;
         5'd9: return 34'sd1048575;
         5'd10: return 34'sd524288;
         5'd11: return 34'sd262144;
         5'd12: return 34'sd131072;
         5'd13: return 34'sd65536;
         5'd14: return 34'sd32768;
         5'd15: return 34'sd16384;
         5'd16: return 34'sd8192;
         5'd17: return 34'sd4096;
         5'd18: return 34'sd2048;
         5'd19: return 34'sd1024;
         5'd20: return 34'sd512;
         5'd21: return 34'sd256;
         5'd22: return 34'sd128;
         5'd23: return 34'sd64;
         default: return '0;
      endcase
   endfunction

endpackage

>>> src/rmte_if.sv
// Valid/ready channel interface carrying an arbitrary payload type.
interface rmte_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/rmte_req_pkg.sv
// Payload types of the request and response channels.
package rmte_req_pkg;
   typedef struct packed {
      logic signed [15:0] m_row2_col0;
      logic signed [15:0] m_row2_col1;
      logic signed [15:0] m_row2_col2;
      logic signed [15:0] m_row0_col1;
      logic signed [15:0] m_row1_col1;
   } req_type;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } rsp_type;
endpackage

>>> src/rmte_cordic_cell.sv
// One vectoring CORDIC micro-rotation stage with its pipeline register.
module rmte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              advance,
   input  rmte_pkg::lane_type lane_in,
   output rmte_pkg::lane_type lane_out
);
   import rmte_pkg::*;

   lane_type lane_ff, lane_in_c;
   vec_type  xs, ys;

   always_comb begin
      xs = lane_in.x >>> STEP;
      ys = lane_in.y >>> STEP;
      lane_in_c = lane_in;
      if (STEP < MaxSteps) begin
         if (!lane_in.y[VecWidth-1]) begin
            lane_in_c.x = lane_in.x + ys;
            lane_in_c.y = lane_in.y - xs;
            lane_in_c.z = lane_in.z + atan_entry(5'(STEP));
         end else begin
            lane_in_c.x = lane_in.x - ys;
            lane_in_c.y = lane_in.y + xs;
            lane_in_c.z = lane_in.z - atan_entry(5'(STEP));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in_c;
      end
   end

   assign lane_out = lane_ff;
endmodule

>>> src/rmte_sqrt_cell.sv
// One restoring square root digit step with its pipeline register.
module rmte_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              advance,
   input  rmte_pkg::sqrt_type sq_in,
   output rmte_pkg::sqrt_type sq_out
);
   import rmte_pkg::*;

   localparam int Shift = 2 * (SqrtSteps - 1 - STEP);

   sqrt_type sq_ff, sq_in_c;
   logic [31:0] trial, partial;

   always_comb begin
      partial = 32'(sq_in.rem >> Shift);
      trial   = {14'd0, sq_in.root, 2'b01};
      sq_in_c = sq_in;
      if (partial >= trial) begin
         sq_in_c.rem  = sq_in.rem - 30'(trial << Shift);
         sq_in_c.root = {sq_in.root[14:0], 1'b1};
      end else begin
         sq_in_c.root = {sq_in.root[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff <= sq_in_c;
      end
   end

   assign sq_out = sq_ff;
endmodule

>>> src/rotation_matrix_to_euler_yxz.sv
// Top level: matrix elements in, yaw, pitch and roll out through CORDIC cell chains.
//
// Each transfer of five Q2.14 matrix elements yields one transfer of three Q3.13
// angles. The block accepts a new matrix every cycle unless the output stalls.
// The pipeline is an input register, a chain of SqrtSteps (15) square root cells
// for the pitch cosine, a prerotation register, one CORDIC cell per iteration in
// each of three lanes, and an output register. Yaw and roll lanes are delayed
// through the square root section so all three lanes march together. The whole
// pipeline stalls as one when the output holds a result that is not taken; the
// output register keeps its result and no transfer is lost.
module rotation_matrix_to_euler_yxz #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   rmte_if.sink   req,
   rmte_if.source rsp
);
   import rmte_pkg::*;
   import rmte_req_pkg::*;

   localparam int Runs = (CORDIC_STEPS < MaxSteps) ? CORDIC_STEPS : MaxSteps;
   localparam int Depth = SqrtSteps + Runs + 3;

   logic [Depth-1:0] valid_ff;
   logic             advance;

   // The pipeline moves whenever the output slot is empty or being taken.
   assign advance   = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Depth-2:0], req.valid};
      end
   end

   // Input register; pitch operand is s = -m21, which fits 17 bits.
   req_type           in_ff;
   logic signed [16:0] s_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req.payload;
         s_ff  <= -{req.payload.m_row2_col1[15], req.payload.m_row2_col1};
      end
   end

   // Square root chain for c = isqrt(2^28 - s^2); yaw and roll operands ride along.
   sqrt_type           sq [SqrtSteps+1];
   req_type            dly [SqrtSteps+1];
   logic signed [16:0] sdly [SqrtSteps+1];
   logic signed [33:0] s_sq;
   logic               sat_now;

   assign s_sq    = s_ff * s_ff;
   assign sat_now = (s_ff >= OneQ14) || (s_ff <= -OneQ14);
   assign sq[0].rem  = sat_now ? '0 : 30'(34'sd268435456 - s_sq);
   assign sq[0].root = '0;
   assign dly[0]  = in_ff;
   assign sdly[0] = s_ff;

   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      rmte_sqrt_cell #(.STEP(g)) u_cell (
         .clock  (clock),
         .advance(advance),
         .sq_in  (sq[g]),
         .sq_out (sq[g+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            dly[g+1]  <= dly[g];
            sdly[g+1] <= sdly[g];
         end
      end
   end

   // Prerotation: zero-vector and negative-x handling, and the pitch clamp.
   function automatic lane_type prerot(input logic signed [16:0] y,
                                       input logic signed [16:0] x);
      lane_type l;
      l = '0;
      l.x = vec_type'(x) <<< 14;
      l.y = vec_type'(y) <<< 14;
      if (x == 0 && y == 0) begin
         l.force_en = 1'b1;
      end else if (x < 0) begin
         l.z = (y >= 0) ? PiZ : -PiZ;
         l.x = -l.x;
         l.y = -l.y;
      end
      return l;
   endfunction

   lane_type lanes [3][Runs+1];
   lane_type pre_yaw, pre_pitch, pre_roll;
   logic signed [16:0] sfin;

   always_comb begin
      sfin      = sdly[SqrtSteps];
      pre_yaw   = prerot({dly[SqrtSteps].m_row2_col0[15], dly[SqrtSteps].m_row2_col0},
                         {dly[SqrtSteps].m_row2_col2[15], dly[SqrtSteps].m_row2_col2});
      pre_roll  = prerot({dly[SqrtSteps].m_row0_col1[15], dly[SqrtSteps].m_row0_col1},
                         {dly[SqrtSteps].m_row1_col1[15], dly[SqrtSteps].m_row1_col1});
      pre_pitch = prerot(sfin, {1'b0, sq[SqrtSteps].root});
      if (sfin >= OneQ14) begin
         pre_pitch.force_en  = 1'b1;
         pre_pitch.force_val = HalfPiOut;
      end else if (sfin <= -OneQ14) begin
         pre_pitch.force_en  = 1'b1;
         pre_pitch.force_val = -HalfPiOut;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lanes[0][0] <= pre_yaw;
         lanes[1][0] <= pre_pitch;
         lanes[2][0] <= pre_roll;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      for (genvar g = 0; g < Runs; g++) begin : g_step
         rmte_cordic_cell #(.STEP(g)) u_cell (
            .clock   (clock),
            .advance (advance),
            .lane_in (lanes[l][g]),
            .lane_out(lanes[l][g+1])
         );
      end
   end

   // Round radians * 2^29 to Q3.13.
   function automatic logic signed [15:0] finish(input lane_type l);
      ang_type r;
      r = l.z + ang_type'(32768);
      if (l.force_en) begin
         return l.force_val;
      end
      return r[31:16];
   endfunction

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.yaw_angle   <= finish(lanes[0][Runs]);
         out_ff.pitch_angle <= finish(lanes[1][Runs]);
         out_ff.roll_angle  <= finish(lanes[2][Runs]);
      end
   end

   assign rsp.valid   = valid_ff[Depth-1];
   assign rsp.payload = out_ff;
endmodule

>>> src/rmte_checker.sv
// Port-level checker for the Euler angle extractor, bound to the top level.
module rmte_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] pitch_angle
);
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input stalled with empty output");
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready) else $error("input stalled while output drains");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pitch_angle <= 16'sd12868 && pitch_angle >= -16'sd12868))
      else $error("pitch out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pitch_angle))
      else $error("stalled result changed");
endmodule

bind rotation_matrix_to_euler_yxz rmte_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .pitch_angle(rsp.payload.pitch_angle)
);

>>> tb/rmte_checker.sv
// Checker that predicts the Euler angles of each matrix transfer and compares the results.
`timescale 1ns / 1ps

module rmte_scoreboard (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  rmte_req_pkg::req_type req_payload,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rmte_req_pkg::rsp_type rsp_payload,
   output int   fail_count,
   output int   pending_count
);
   import rmte_pkg::*;
   import rmte_req_pkg::*;

   localparam int Steps = 16;

   rsp_type angle_queue[$];

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [15:0] atan2_angle(longint yi, longint xi);
      longint x, y, z, xs, ys;
      longint r;
      z = 0;
      if (xi == 0 && yi == 0) return 16'sd0;
      x = xi * 16384;
      y = yi * 16384;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd1686629713 : -64'sd1686629713;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < Steps && i < MaxSteps; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atan_entry(5'(i)));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atan_entry(5'(i)));
         end
      end
      r = shr_floor(z + 32768, 16);
      return r[15:0];
   endfunction

   function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic logic signed [15:0] asin_angle(longint s);
      if (s >= 16384) return HalfPiOut;
      if (s <= -16384) return -HalfPiOut;
      return atan2_angle(s, root_floor(268435456 - s * s));
   endfunction

   function automatic rsp_type euler_angles(req_type m);
      rsp_type a;
      a.yaw_angle   = atan2_angle(m.m_row2_col0, m.m_row2_col2);
      a.pitch_angle = asin_angle(-longint'(m.m_row2_col1));
      a.roll_angle  = atan2_angle(m.m_row0_col1, m.m_row1_col1);
      return a;
   endfunction

   assign pending_count = angle_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) angle_queue.push_back(euler_angles(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (angle_queue.size() == 0) begin
               $error("unexpected result transfer %h", rsp_payload);
               fail_count++;
            end else begin
               want = angle_queue.pop_front();
               if (want.yaw_angle !== rsp_payload.yaw_angle) begin
                  $error("yaw_angle expected %0d actual %0d",
                         want.yaw_angle, rsp_payload.yaw_angle);
                  fail_count++;
               end
               if (want.pitch_angle !== rsp_payload.pitch_angle) begin
                  $error("pitch_angle expected %0d actual %0d",
                         want.pitch_angle, rsp_payload.pitch_angle);
                  fail_count++;
               end
               if (want.roll_angle !== rsp_payload.roll_angle) begin
                  $error("roll_angle expected %0d actual %0d",
                         want.roll_angle, rsp_payload.roll_angle);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

>>> tb/tb_rotation_matrix_to_euler_yxz.sv
// Testbench top: drives matrix transfers and result stalls, and reports the verdict.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler_yxz;
   import rmte_req_pkg::*;

   // Latency is the pipeline depth of the default configuration; drain waits longer.
   localparam int Latency    = 34;
   localparam int IdleLimit  = 2000;
   localparam int RandomItems = 1250;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;

   rmte_if #(.payload_type(req_type)) req (.clock(clock));
   rmte_if #(.payload_type(rsp_type)) rsp (.clock(clock));

   rotation_matrix_to_euler_yxz DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   rmte_scoreboard checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_payload(req.payload),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .rsp_payload(rsp.payload),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Picks an element value: often a plausible rotation entry, sometimes an
   // extreme, sometimes fully random, so every bit of each field toggles.
   function automatic logic signed [15:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd16384;
         3: return -16'sd16384;
         4: return 16'sd0;
         5, 6: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Sends one matrix, first waiting a random gap unless no_gap is set. The valid is
   // only lowered after the transfer, so back to back items keep it high.
   task automatic send_matrix(req_type m, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= m;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_fields(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c, logic signed [15:0] d,
                              logic signed [15:0] e);
      req_type m;
      m.m_row2_col0 = a;
      m.m_row2_col1 = b;
      m.m_row2_col2 = c;
      m.m_row0_col1 = d;
      m.m_row1_col1 = e;
      send_matrix(m, 1'b0);
   endtask

   // Result side: each result waits its own random stall, with stretches of
   // no stalling at all.
   initial begin
      int stall;
      bit steady;
      rsp.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if ($urandom_range(0, 99) == 0) steady = !steady;
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   // Watchdog: cycles with no transfer on either channel.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      req_type m;
      bit burst;
      req.valid   <= 1'b0;
      req.payload <= '0;
      reset       <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: both atan2 operands zero, negative x with y of either
      // sign, pitch operand at and beyond one including the most negative
      // element, and the field extremes.
      send_fields(0, 0, 0, 0, 0);
      send_fields(16384, 0, -16384, 0, -16384);
      send_fields(-16384, 0, -16384, -1, -16384);
      send_fields(0, -16384, 16384, 16384, 0);
      send_fields(0, 16384, 0, -16384, 0);
      send_fields(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_fields(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_fields(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_fields(0, 16383, -1, 0, 16'sh8000);
      send_fields(0, -16383, 1, 1, -1);
      send_fields(0, 16385, 0, 16'sh7fff, 16'sh8000);
      send_fields(0, -16385, 16'sh8000, 0, 0);
      send_fields(11585, -11585, 11585, 11585, 11585);
      send_fields(-1, 1, -1, 1, -1);

      // Random part, partly in bursts with valid held high.
      burst = 1'b0;
      for (int n = 0; n < RandomItems; n++) begin
         if ($urandom_range(0, 49) == 0) burst = !burst;
         m.m_row2_col0 = pick_element();
         m.m_row2_col1 = pick_element();
         m.m_row2_col2 = pick_element();
         m.m_row0_col1 = pick_element();
         m.m_row1_col1 = pick_element();
         send_matrix(m, burst);
      end
      req.valid <= 1'b0;

      // Drain: wait for every expected result, then wait longer than the pipeline latency.
      while (pending_count != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
src/rmte_pkg.sv
src/rmte_if.sv
src/rmte_req_pkg.sv
src/rmte_cordic_cell.sv
src/rmte_sqrt_cell.sv
src/rotation_matrix_to_euler_yxz.sv
src/rmte_checker.sv
tb/rmte_checker.sv
tb/tb_rotation_matrix_to_euler_yxz.sv
